// ===== rtl/color_difference_peak_locator_top_defines.svh =====
// Assertion macros shared by the color difference peak locator RTL.
// Self-contained; included by the modules that carry assertions.
`ifndef COLOR_DIFFERENCE_PEAK_LOCATOR_TOP_DEFINES_SVH
`define COLOR_DIFFERENCE_PEAK_LOCATOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define CDPL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cdpl assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CDPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdpl assertion failed");

`else

`define CDPL_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define CDPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/cdpl_pkg.sv =====
// Types and constants of the color difference peak locator.
// No dependencies; used by every module of the block.
package cdpl_pkg;

    localparam int CH_W     = 8;
    localparam int SQ_W     = 16;
    localparam int SUM_W    = 18;
    localparam int ROOT_W   = 8;
    localparam int POS_W    = 11;
    localparam int CFG_W    = 12;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    // Radicand used when the squared sum reaches 65536 or more; its root is 255.
    localparam logic [SQ_W-1:0] RADICAND_SAT = 16'hFFFF;

    typedef struct packed {
        logic [CH_W-1:0] cur_c0;
        logic [CH_W-1:0] cur_c1;
        logic [CH_W-1:0] cur_c2;
        logic [CH_W-1:0] ref_c0;
        logic [CH_W-1:0] ref_c1;
        logic [CH_W-1:0] ref_c2;
    } pix_word_t;

    typedef struct packed {
        logic [POS_W-1:0]  spot_col;
        logic [POS_W-1:0]  spot_row;
        logic [ROOT_W-1:0] peak_level;
    } spot_word_t;

    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
    } pos_tag_t;

    typedef struct packed {
        logic [SQ_W-1:0]   radicand;
        logic [ROOT_W-1:0] root;
        pos_tag_t          tag;
    } root_stage_t;

endpackage

// ===== rtl/cdpl_front.sv =====
// Input stage: raster position counters and the saturated sum of squared differences.
// Depends on cdpl_pkg.
module cdpl_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  cdpl_pkg::pix_word_t       in_word,
    input  logic [cdpl_pkg::CFG_W-1:0] width_cfg,
    input  logic [cdpl_pkg::CFG_W-1:0] height_cfg,
    output logic                      out_valid,
    input  logic                      out_ready,
    output cdpl_pkg::root_stage_t     out_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int SWW = (CW + 1 > cdpl_pkg::CFG_W) ? CW + 1 : cdpl_pkg::CFG_W;
    localparam int SWH = (RW + 1 > cdpl_pkg::CFG_W) ? RW + 1 : cdpl_pkg::CFG_W;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          valid_reg;
    cdpl_pkg::root_stage_t data_reg, data_next;

    logic [SWW-1:0] width_eff;
    logic [SWH-1:0] height_eff;
    logic           row_end, frame_end, accept;
    logic [cdpl_pkg::CH_W-1:0] d0, d1, d2;
    logic [cdpl_pkg::SUM_W-1:0] sum;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        // Zero sizes act as one, oversize ones saturate at the bound.
        if (width_cfg == '0)
            width_eff = SWW'(1);
        else if (SWW'(width_cfg) > SWW'(MAX_WIDTH))
            width_eff = SWW'(MAX_WIDTH);
        else
            width_eff = SWW'(width_cfg);

        if (height_cfg == '0)
            height_eff = SWH'(1);
        else if (SWH'(height_cfg) > SWH'(MAX_HEIGHT))
            height_eff = SWH'(MAX_HEIGHT);
        else
            height_eff = SWH'(height_cfg);

        row_end   = (SWW'(col_reg) + SWW'(1)) >= width_eff;
        frame_end = row_end && ((SWH'(row_reg) + SWH'(1)) >= height_eff);

        col_next = row_end ? '0 : col_reg + CW'(1);
        if (!row_end)
            row_next = row_reg;
        else if (frame_end)
            row_next = '0;
        else
            row_next = row_reg + RW'(1);

        d0 = (in_word.cur_c0 > in_word.ref_c0) ? in_word.cur_c0 - in_word.ref_c0
                                               : in_word.ref_c0 - in_word.cur_c0;
        d1 = (in_word.cur_c1 > in_word.ref_c1) ? in_word.cur_c1 - in_word.ref_c1
                                               : in_word.ref_c1 - in_word.cur_c1;
        d2 = (in_word.cur_c2 > in_word.ref_c2) ? in_word.cur_c2 - in_word.ref_c2
                                               : in_word.ref_c2 - in_word.cur_c2;
        sum = cdpl_pkg::SUM_W'(d0) * cdpl_pkg::SUM_W'(d0)
            + cdpl_pkg::SUM_W'(d1) * cdpl_pkg::SUM_W'(d1)
            + cdpl_pkg::SUM_W'(d2) * cdpl_pkg::SUM_W'(d2);

        data_next.radicand = (sum[cdpl_pkg::SUM_W-1:cdpl_pkg::SQ_W] != '0)
                           ? cdpl_pkg::RADICAND_SAT : sum[cdpl_pkg::SQ_W-1:0];
        data_next.root     = '0;
        data_next.tag.col  = cdpl_pkg::POS_W'(col_reg);
        data_next.tag.row  = cdpl_pkg::POS_W'(row_reg);
        data_next.tag.last = frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (in_ready)
                valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            data_reg <= data_next;
    end

endmodule

// ===== rtl/cdpl_root_cell.sv =====
// One cell of the square root chain: decides a single bit of the root.
// Depends on cdpl_pkg.
module cdpl_root_cell #(
    parameter int BIT_POS = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  cdpl_pkg::root_stage_t in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output cdpl_pkg::root_stage_t out_data
);

    localparam logic [cdpl_pkg::ROOT_W-1:0] TRIAL_BIT = cdpl_pkg::ROOT_W'(1) << BIT_POS;

    logic                  valid_reg;
    cdpl_pkg::root_stage_t data_reg, data_next;
    logic [cdpl_pkg::ROOT_W-1:0] trial;
    logic [cdpl_pkg::SQ_W-1:0]   trial_sq;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        trial     = in_data.root | TRIAL_BIT;
        trial_sq  = trial * trial;
        data_next = in_data;
        if (trial_sq <= in_data.radicand)
            data_next.root = trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

// ===== rtl/cdpl_peak_track.sv =====
// Running peak of the frame, spot location and the output register.
// Depends on cdpl_pkg and the assertion macro header.
`include "color_difference_peak_locator_top_defines.svh"

module cdpl_peak_track (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  cdpl_pkg::root_stage_t in_data,
    output logic                  spot_valid,
    input  logic                  spot_ready,
    output cdpl_pkg::spot_word_t  spot
);

    logic [cdpl_pkg::ROOT_W-1:0] peak_reg, peak_next;
    logic [cdpl_pkg::POS_W-1:0]  best_col_reg, best_col_next;
    logic [cdpl_pkg::POS_W-1:0]  best_row_reg, best_row_next;
    logic                        spot_valid_reg;
    cdpl_pkg::spot_word_t        spot_reg;
    logic                        take, beat;

    // Only a frame-ending word needs the output register to be free.
    assign in_ready   = !in_data.tag.last || !spot_valid_reg || spot_ready;
    assign take       = in_valid && in_ready;
    assign spot_valid = spot_valid_reg;
    assign spot       = spot_reg;

    always_comb
    begin
        beat          = in_data.root > peak_reg;
        peak_next     = beat ? in_data.root : peak_reg;
        best_col_next = beat ? in_data.tag.col : best_col_reg;
        best_row_next = beat ? in_data.tag.row : best_row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg       <= '0;
            best_col_reg   <= '0;
            best_row_reg   <= '0;
            spot_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                best_col_reg <= best_col_next;
                best_row_reg <= best_row_next;
                peak_reg     <= in_data.tag.last ? '0 : peak_next;
            end
            if (take && in_data.tag.last)
                spot_valid_reg <= 1'b1;
            else if (spot_ready)
                spot_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_data.tag.last)
        begin
            spot_reg.spot_col   <= best_col_next;
            spot_reg.spot_row   <= best_row_next;
            spot_reg.peak_level <= peak_next;
        end
    end

    `CDPL_ASSERT_NEXT(a_peak_restarts, clk, rst_n, take && in_data.tag.last, peak_reg == '0)
    `CDPL_ASSERT_NEXT(a_peak_grows, clk, rst_n, take && !in_data.tag.last,
                      peak_reg >= $past(peak_reg))
    `CDPL_ASSERT_NEXT(a_spot_moves, clk, rst_n, take && beat,
                      best_col_reg == $past(in_data.tag.col) &&
                      best_row_reg == $past(in_data.tag.row))
    `CDPL_ASSERT_NOW(a_no_overwrite, clk, rst_n, spot_valid_reg && !spot_ready,
                     !(take && in_data.tag.last))

endmodule

// ===== rtl/color_difference_peak_locator_top.sv =====
// Top level of the color difference peak locator.
// Depends on cdpl_pkg, cdpl_front, cdpl_root_cell, cdpl_peak_track.
//
// Channel   Direction  Word          Handshake
// pix       in         pix_word_t    pix_valid / pix_ready
// spot      out        spot_word_t   spot_valid / spot_ready
// cfg       in         12-bit data   cfg_we, index cfg_addr
//
// One pixel word is taken per clock unless the result word is held back; the
// chain of eight root cells is pipelined, each cell resolving one bit of the root.
// The tracker registers the result when a frame's last word leaves the root cells.
// Reset clears the raster position, the running peak, the spot location and
// all valid bits, and loads a 640 by 480 frame size.
// pix_ready drops only while a frame-ending word sits at the peak tracker and
// the previous result word has not yet been taken.
module color_difference_peak_locator_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pix_valid,
    output logic                                pix_ready,
    input  cdpl_pkg::pix_word_t                 pix,
    output logic                                spot_valid,
    input  logic                                spot_ready,
    output cdpl_pkg::spot_word_t                spot,
    input  logic                                cfg_we,
    input  logic [cdpl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [cdpl_pkg::CFG_W-1:0]          cfg_data
);

    logic [cdpl_pkg::CFG_W-1:0] width_reg;
    logic [cdpl_pkg::CFG_W-1:0] height_reg;

    // Stage 0 is the front stage; stage k+1 is the output of root cell k.
    cdpl_pkg::root_stage_t stage_data  [0:cdpl_pkg::ROOT_W];
    logic                  stage_valid [0:cdpl_pkg::ROOT_W];
    logic                  stage_ready [0:cdpl_pkg::ROOT_W];

    // Frame size registers; the raw value is stored and clamped where it is used.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= cdpl_pkg::FRAME_WIDTH_RST;
            height_reg <= cdpl_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                cdpl_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                cdpl_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data;
            endcase
        end
    end

    // The front stage tags each pixel with its raster position and whether it
    // closes the frame, and forms the saturated squared color distance.
    cdpl_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (pix_valid),
        .in_ready   (pix_ready),
        .in_word    (pix),
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .out_valid  (stage_valid[0]),
        .out_ready  (stage_ready[0]),
        .out_data   (stage_data[0])
    );

    // The root cells settle the root from its top bit down, one bit per cell.
    for (genvar k = 0; k < cdpl_pkg::ROOT_W; k++)
    begin : g_root
        cdpl_root_cell #(
            .BIT_POS (cdpl_pkg::ROOT_W - 1 - k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[k]),
            .in_ready  (stage_ready[k]),
            .in_data   (stage_data[k]),
            .out_valid (stage_valid[k+1]),
            .out_ready (stage_ready[k+1]),
            .out_data  (stage_data[k+1])
        );
    end

    // The tracker keeps the first strict maximum of the frame and emits the
    // result word when the frame's last pixel passes through it.
    cdpl_peak_track u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (stage_valid[cdpl_pkg::ROOT_W]),
        .in_ready   (stage_ready[cdpl_pkg::ROOT_W]),
        .in_data    (stage_data[cdpl_pkg::ROOT_W]),
        .spot_valid (spot_valid),
        .spot_ready (spot_ready),
        .spot       (spot)
    );

endmodule
